/* rtl/core/hcd_pkg.sv */
// hcd_pkg: shared constants and types for the hsl colour distance core
// no dependencies; imported by hcd_div, hcd_sqrt and hsl_color_distance_core
package hcd_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned CH_W              = 8;
  // widest numerator or divisor: 6 * chroma reaches 1530
  localparam int unsigned DIV_W             = 11;
  // lightness divisor: twice the channel maximum
  localparam logic [DIV_W-1:0] LIGHT_DEN    = 11'd510;

  typedef struct packed {
    logic [DIV_W-1:0] l_num;
    logic [DIV_W-1:0] s_num;
    logic [DIV_W-1:0] s_den;
    logic [DIV_W-1:0] h_num;
    logic [DIV_W-1:0] h_den;
  } hcd_div_in_t;

endpackage

/* rtl/core/hcd_div.sv */
// hcd_div: pipelined restoring divider, one quotient bit per stage, round to nearest
// depends on hcd_pkg for the operand width
module hcd_div #(
  parameter int unsigned QW = 17,
  parameter int unsigned NW = hcd_pkg::DIV_W
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic [QW-1:0] quo_o
);
  import hcd_pkg::*;

  localparam int unsigned RW = NW + 2;

  logic [RW-1:0] rem_q [QW];
  logic [RW-1:0] rem_d [QW];
  logic [NW:0]   den_q [QW];
  logic [NW:0]   den_d [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] low_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];

  // dividend is num * 2^(QW) + den over divisor 2 * den: rounds half up
  always_comb begin
    logic [RW-1:0] r_p;
    logic [RW-1:0] t;
    logic [QW-1:0] l_p;
    logic [QW-1:0] q_p;
    logic [NW:0]   d_p;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r_p = RW'(num_i);
        l_p = QW'(den_i);
        q_p = '0;
        d_p = {den_i, 1'b0};
      end else begin
        r_p = rem_q[k-1];
        l_p = low_q[k-1];
        q_p = quo_q[k-1];
        d_p = den_q[k-1];
      end
      t = {r_p[RW-2:0], l_p[QW-1]};
      if (t >= RW'(d_p)) begin
        rem_d[k] = t - RW'(d_p);
        quo_d[k] = {q_p[QW-2:0], 1'b1};
      end else begin
        rem_d[k] = t;
        quo_d[k] = {q_p[QW-2:0], 1'b0};
      end
      low_d[k] = {l_p[QW-2:0], 1'b0};
      den_d[k] = d_p;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      rem_q[k] <= rem_d[k];
      low_q[k] <= low_d[k];
      quo_q[k] <= quo_d[k];
      den_q[k] <= den_d[k];
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* rtl/core/hcd_sqrt.sv */
// hcd_sqrt: pipelined digit-by-digit square root, one root bit per stage, rounded
// depends on hcd_pkg for the default fraction width
module hcd_sqrt #(
  parameter int unsigned FB = hcd_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk_i,
  input  logic [2*FB+1:0] x_i,
  output logic [FB:0]     root_o
);
  import hcd_pkg::*;

  localparam int unsigned N  = FB + 1;
  localparam int unsigned XW = 2 * N;
  localparam int unsigned RW = FB + 4;

  logic [RW-1:0] rem_q  [N];
  logic [RW-1:0] rem_d  [N];
  logic [N-1:0]  root_q [N];
  logic [N-1:0]  root_d [N];
  logic [XW-1:0] x_q    [N];
  logic [XW-1:0] x_d    [N];
  logic [N-1:0]  res_q;

  always_comb begin
    logic [RW-1:0] r_p;
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic [N-1:0]  o_p;
    logic [XW-1:0] x_p;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        r_p = '0;
        o_p = '0;
        x_p = x_i;
      end else begin
        r_p = rem_q[k-1];
        o_p = root_q[k-1];
        x_p = x_q[k-1];
      end
      t     = {r_p[RW-3:0], x_p[XW-1:XW-2]};
      trial = RW'({o_p[N-2:0], 2'b01});
      if (t >= trial) begin
        rem_d[k]  = t - trial;
        root_d[k] = {o_p[N-2:0], 1'b1};
      end else begin
        rem_d[k]  = t;
        root_d[k] = {o_p[N-2:0], 1'b0};
      end
      x_d[k] = {x_p[XW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      x_q[k]    <= x_d[k];
    end
    // round up when the remainder exceeds the root
    res_q <= root_q[N-1] + N'(rem_q[N-1] > RW'(root_q[N-1]));
  end

  assign root_o = res_q;

endmodule

/* rtl/core/hsl_color_distance_core.sv */
// hsl_color_distance_core: top level, rgb pair to hsl distance in one pipeline
// depends on hcd_pkg, hcd_div and hcd_sqrt
//
// One pixel pair is taken in every clock cycle (start_i high; busy_o is
// always low) and its distance leaves on distance_o with done_o high for one
// cycle, in order. The depth comes from the two bit-serial units: four
// dividers of FRACTION_BITS+1 stages each for saturation and hue, and a
// square root of FRACTION_BITS+1 stages plus a rounding stage. Lightness
// divides by the constant 510, so it is a reciprocal multiply that waits in
// a delay line beside the dividers. The result cannot be held off, so
// nothing ever stalls and no item is dropped.
module hsl_color_distance_core #(
  parameter int unsigned FRACTION_BITS = hcd_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [hcd_pkg::CH_W-1:0]  a_red_i,
  input  logic [hcd_pkg::CH_W-1:0]  a_green_i,
  input  logic [hcd_pkg::CH_W-1:0]  a_blue_i,
  input  logic [hcd_pkg::CH_W-1:0]  b_red_i,
  input  logic [hcd_pkg::CH_W-1:0]  b_green_i,
  input  logic [hcd_pkg::CH_W-1:0]  b_blue_i,
  output logic                      done_o,
  output logic [FRACTION_BITS:0]    distance_o
);
  import hcd_pkg::*;

  localparam int unsigned QW  = FRACTION_BITS + 1;   // h, s, l and root width
  localparam int unsigned SW  = 2 * QW;              // squares and their sum
  localparam int unsigned LAT = 2 * QW + 5;
  localparam logic [QW-1:0] ONE_FX  = QW'(1) << FRACTION_BITS;
  localparam logic [QW-1:0] HALF_FX = QW'(1) << (FRACTION_BITS - 1);

  // lightness: round(sum * 2^F / 510) = floor((sum * 2^(F-1) + 127) / 255),
  // done as a multiply by ceil(2^(F+16) / 255) and a shift by F+16
  localparam int unsigned LW = FRACTION_BITS + 8;
  localparam int unsigned MW = FRACTION_BITS + 9;
  localparam int unsigned PW = LW + MW;
  localparam longint unsigned LIGHT_RECIP_W =
    ((64'd1 << (FRACTION_BITS + 16)) + 64'd254) / 64'd255;
  localparam logic [MW-1:0] LIGHT_RECIP = MW'(LIGHT_RECIP_W);
  localparam logic [LW-1:0] LIGHT_BIAS  = LW'(127);

  // divider lanes: 0, 1 first pixel s, h; 2, 3 second pixel s, h
  logic [DIV_W-1:0] num_q [4];
  logic [DIV_W-1:0] den_q [4];
  logic [QW-1:0]    quo   [4];

  // lightness sums wait beside the dividers, then one multiply stage
  logic [DIV_W-1:0] lsum_q [2][QW];
  logic [QW-1:0]    lit_q  [2];

  logic [LAT-1:0] vld_q;
  logic [QW-1:0]  dh_q, ds_q, dl_q;
  logic [SW-1:0]  sqh_q, sqs_q, sql_q;
  logic [SW-1:0]  sum_q;
  logic [QW-1:0]  dh_raw;

  hcd_div_in_t pa, pb;

  // max, min, chroma and the sextant numerator of one pixel
  function automatic hcd_div_in_t prep(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                       input logic [CH_W-1:0] b);
    logic [CH_W-1:0]  mx, mn;
    logic [DIV_W-1:0] c, s, n;
    hcd_div_in_t      o;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = DIV_W'(mx) - DIV_W'(mn);
    s = DIV_W'(mx) + DIV_W'(mn);
    // tie order: red, then green, then blue
    if (mx == r) begin
      n = (c * DIV_W'(6)) + DIV_W'(g) - DIV_W'(b);
      if (g >= b) n = DIV_W'(g) - DIV_W'(b);
    end else if (mx == g) begin
      n = (c << 1) + DIV_W'(b) - DIV_W'(r);
    end else begin
      n = (c << 2) + DIV_W'(r) - DIV_W'(g);
    end
    o.l_num = s;
    if (c == '0) begin
      // gray pixel: zero hue and saturation, safe divisor
      o.s_num = '0;
      o.s_den = DIV_W'(1);
      o.h_num = '0;
      o.h_den = DIV_W'(1);
    end else begin
      o.s_num = c;
      o.s_den = (s <= DIV_W'(255)) ? s : (LIGHT_DEN - s);
      o.h_num = n;
      o.h_den = c * DIV_W'(6);
    end
    return o;
  endfunction

  // lightness from max plus min by reciprocal multiplication
  function automatic logic [QW-1:0] light_of(input logic [DIV_W-1:0] s);
    logic [LW-1:0] x;
    logic [PW-1:0] p;
    x = (LW'(s) << (FRACTION_BITS - 1)) + LIGHT_BIAS;
    p = PW'(x) * PW'(LIGHT_RECIP);
    return p[PW-1 -: QW];
  endfunction

  assign pa = prep(a_red_i, a_green_i, a_blue_i);
  assign pb = prep(b_red_i, b_green_i, b_blue_i);

  // stage one: divider operands
  always_ff @(posedge clk_i) begin
    num_q[0] <= pa.s_num;  den_q[0] <= pa.s_den;
    num_q[1] <= pa.h_num;  den_q[1] <= pa.h_den;
    num_q[2] <= pb.s_num;  den_q[2] <= pb.s_den;
    num_q[3] <= pb.h_num;  den_q[3] <= pb.h_den;
  end

  // lightness delay line, aligned with the divider outputs
  always_ff @(posedge clk_i) begin
    lsum_q[0][0] <= pa.l_num;
    lsum_q[1][0] <= pb.l_num;
    for (int k = 1; k < QW; k++) begin
      lsum_q[0][k] <= lsum_q[0][k-1];
      lsum_q[1][k] <= lsum_q[1][k-1];
    end
    lit_q[0] <= light_of(lsum_q[0][QW-1]);
    lit_q[1] <= light_of(lsum_q[1][QW-1]);
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    hcd_div #(
      .QW (QW),
      .NW (DIV_W)
    ) u_div (
      .clk_i (clk_i),
      .num_i (num_q[i]),
      .den_i (den_q[i]),
      .quo_o (quo[i])
    );
  end

  // absolute hue difference, folded to the shorter arc when registered
  assign dh_raw = (quo[1] >= quo[3]) ? (quo[1] - quo[3]) : (quo[3] - quo[1]);

  always_ff @(posedge clk_i) begin
    dh_q  <= (dh_raw > HALF_FX) ? (ONE_FX - dh_raw) : dh_raw;
    ds_q  <= (quo[0] >= quo[2]) ? (quo[0] - quo[2]) : (quo[2] - quo[0]);
    dl_q  <= (lit_q[0] >= lit_q[1]) ? (lit_q[0] - lit_q[1]) : (lit_q[1] - lit_q[0]);
    // squares, one multiplier each
    sqh_q <= SW'(dh_q) * SW'(dh_q);
    sqs_q <= SW'(ds_q) * SW'(ds_q);
    sql_q <= SW'(dl_q) * SW'(dl_q);
    // exact sum at twice the fraction width
    sum_q <= sqh_q + sqs_q + sql_q;
  end

  hcd_sqrt #(
    .FB (FRACTION_BITS)
  ) u_sqrt (
    .clk_i  (clk_i),
    .x_i    (sum_q),
    .root_o (distance_o)
  );

  // valid bits travel beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[LAT-1];

`ifndef SYNTH
  a_hue_arc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QW+1] |-> (dh_q <= HALF_FX))
    else $error("hue difference above half a turn");
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QW] |-> (quo[0] <= ONE_FX) && (quo[1] <= ONE_FX) && (lit_q[0] <= ONE_FX))
    else $error("hsl component above one");
  a_dist_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (distance_o <= QW'(ONE_FX + HALF_FX)))
    else $error("distance above one and a half");
`endif

endmodule
